// ===== hdl/pts_reorder_rate_detector_defines.svh =====
// assertion macros for the timestamp reorder block
`ifndef PTS_REORDER_RATE_DETECTOR_DEFINES_SVH
`define PTS_REORDER_RATE_DETECTOR_DEFINES_SVH

// implication checked on every clock edge outside reset
`define PRD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// plain condition checked on every clock edge outside reset
`define PRD_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

`endif

// ===== hdl/prd_pkg.sv =====
`default_nettype none

package prd_pkg;

  // fixed widths of the time base register and the rounded quotient
  localparam int TB_W = 24;
  localparam int QR_W = TB_W + 1;

  // parameter defaults
  localparam int DEFAULT_RELEASE_DEPTH = 16;
  localparam int DEFAULT_TIME_WIDTH    = 48;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = TB_W;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_BASE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_PTS = 1'b1;
  localparam logic [TB_W-1:0] TIME_BASE_RESET = 24'd1000000;

  // item modes
  localparam logic MODE_PUSH  = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  // items waiting between front and back
  localparam int QUEUE_DEPTH = 2;

  // frame rates that get a class
  localparam int HZ_24 = 24;
  localparam int HZ_25 = 25;
  localparam int HZ_30 = 30;
  localparam int HZ_50 = 50;
  localparam int HZ_60 = 60;

  typedef enum logic [2:0] {
    RATE_NONE = 3'd0,
    RATE_24   = 3'd1,
    RATE_25   = 3'd2,
    RATE_30   = 3'd3,
    RATE_50   = 3'd4,
    RATE_60   = 3'd5
  } rate_class_t;

  // commands from the sequencer to the sorted store
  typedef struct packed {
    logic ins;
    logic pop;
    logic clr;
  } store_cmd_t;

  // rounded frame rate to class
  function automatic rate_class_t rate_class_of(input logic [QR_W-1:0] rate);
    rate_class_t cls;
    begin
      unique case (rate)
        QR_W'(HZ_24): cls = RATE_24;
        QR_W'(HZ_25): cls = RATE_25;
        QR_W'(HZ_30): cls = RATE_30;
        QR_W'(HZ_50): cls = RATE_50;
        QR_W'(HZ_60): cls = RATE_60;
        default:      cls = RATE_NONE;
      endcase
      return cls;
    end
  endfunction

endpackage

`default_nettype wire

// ===== hdl/pts_reorder_rate_detector.sv =====
// an item is queued in the front and taken by the back sequencer while it is idle; a flush
// gives its result straight from idle, a push passes the check state, and a release may run
// the 24-step serial rate divider; the back takes no new item until it is back in idle;
// a 2-item queue in front lets start be taken while the back is working
// results leave on out_strobe for one cycle, the receiver cannot stall
// synchronous active-low reset empties the store, clears the rate class, sets time base 1000000
`default_nettype none

module pts_reorder_rate_detector #(
  parameter int RELEASE_DEPTH = prd_pkg::DEFAULT_RELEASE_DEPTH,
  parameter int TIME_WIDTH    = prd_pkg::DEFAULT_TIME_WIDTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic                           in_mode,
  input  wire logic [TIME_WIDTH-1:0]          in_decode_time,
  input  wire logic                           in_decode_valid,
  input  wire logic [TIME_WIDTH-1:0]          in_present_time,
  input  wire logic                           in_present_valid,
  output logic                                out_strobe,
  output logic                                out_released,
  output logic [TIME_WIDTH-1:0]               out_released_time,
  output logic                                out_released_time_ok,
  output logic signed [TIME_WIDTH:0]          out_interval,
  output logic [2:0]                          out_rate_class,
  output logic [$clog2(RELEASE_DEPTH+2)-1:0]  out_fill_level,
  input  wire logic                           cfg_we,
  input  wire logic [prd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [prd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import prd_pkg::*;

  logic [TB_W-1:0]       time_base_r;
  logic                  ignore_pts_r;

  logic                  q_valid;
  logic                  q_ready;
  logic                  q_mode;
  logic [TIME_WIDTH-1:0] q_decode_time;
  logic                  q_decode_valid;
  logic [TIME_WIDTH-1:0] q_present_time;
  logic                  q_present_valid;
  logic [TIME_WIDTH-1:0] q_key;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_base_r  <= TIME_BASE_RESET;
      ignore_pts_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TIME_BASE:  time_base_r  <= cfg_wdata[TB_W-1:0];
        CFG_IGNORE_PTS: ignore_pts_r <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // front: accept, classify, queue
  prd_front #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_mode          (in_mode),
    .in_decode_time   (in_decode_time),
    .in_decode_valid  (in_decode_valid),
    .in_present_time  (in_present_time),
    .in_present_valid (in_present_valid),
    .ignore_pts       (ignore_pts_r),
    .q_valid          (q_valid),
    .q_ready          (q_ready),
    .q_mode           (q_mode),
    .q_decode_time    (q_decode_time),
    .q_decode_valid   (q_decode_valid),
    .q_present_time   (q_present_time),
    .q_present_valid  (q_present_valid),
    .q_key            (q_key)
  );

  // back: sorted store, release and rate detection
  prd_back #(
    .TIME_WIDTH    (TIME_WIDTH),
    .RELEASE_DEPTH (RELEASE_DEPTH)
  ) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .time_base            (time_base_r),
    .q_valid              (q_valid),
    .q_ready              (q_ready),
    .q_mode               (q_mode),
    .q_decode_time        (q_decode_time),
    .q_decode_valid       (q_decode_valid),
    .q_present_time       (q_present_time),
    .q_present_valid      (q_present_valid),
    .q_key                (q_key),
    .out_strobe           (out_strobe),
    .out_released         (out_released),
    .out_released_time    (out_released_time),
    .out_released_time_ok (out_released_time_ok),
    .out_interval         (out_interval),
    .out_rate_class       (out_rate_class),
    .out_fill_level       (out_fill_level)
  );

endmodule

`default_nettype wire

// ===== hdl/prd_front.sv =====
`default_nettype none

module prd_front #(
  parameter int TIME_WIDTH = prd_pkg::DEFAULT_TIME_WIDTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic                  in_mode,
  input  wire logic [TIME_WIDTH-1:0] in_decode_time,
  input  wire logic                  in_decode_valid,
  input  wire logic [TIME_WIDTH-1:0] in_present_time,
  input  wire logic                  in_present_valid,
  input  wire logic                  ignore_pts,
  output logic                       q_valid,
  input  wire logic                  q_ready,
  output logic                       q_mode,
  output logic [TIME_WIDTH-1:0]      q_decode_time,
  output logic                       q_decode_valid,
  output logic [TIME_WIDTH-1:0]      q_present_time,
  output logic                       q_present_valid,
  output logic [TIME_WIDTH-1:0]      q_key
);
  import prd_pkg::*;

  localparam int QP_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

  logic                  mode_q    [QUEUE_DEPTH];
  logic [TIME_WIDTH-1:0] dt_q      [QUEUE_DEPTH];
  logic                  dv_q      [QUEUE_DEPTH];
  logic [TIME_WIDTH-1:0] pt_q      [QUEUE_DEPTH];
  logic                  pv_q      [QUEUE_DEPTH];
  logic [TIME_WIDTH-1:0] key_q     [QUEUE_DEPTH];

  logic [QP_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QP_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QC_W-1:0] cnt_r, cnt_nxt;

  logic                  accept;
  logic                  take;
  logic                  pv;
  logic [TIME_WIDTH-1:0] key;

  // classify the incoming item
  assign pv  = in_present_valid && !ignore_pts;
  assign key = pv ? in_present_time : (in_decode_valid ? in_decode_time : '0);

  assign busy    = (cnt_r == QC_W'(QUEUE_DEPTH));
  assign accept  = start && !busy;
  assign q_valid = (cnt_r != '0);
  assign take    = q_valid && q_ready;

  // queue pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (accept) begin
      wr_ptr_nxt = (wr_ptr_r == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (take) begin
      rd_ptr_nxt = (rd_ptr_r == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (accept && !take) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (take && !accept) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue payload
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q[wr_ptr_r] <= in_mode;
      dt_q[wr_ptr_r]   <= in_decode_time;
      dv_q[wr_ptr_r]   <= in_decode_valid;
      pt_q[wr_ptr_r]   <= in_present_time;
      pv_q[wr_ptr_r]   <= pv;
      key_q[wr_ptr_r]  <= key;
    end
  end

  assign q_mode          = mode_q[rd_ptr_r];
  assign q_decode_time   = dt_q[rd_ptr_r];
  assign q_decode_valid  = dv_q[rd_ptr_r];
  assign q_present_time  = pt_q[rd_ptr_r];
  assign q_present_valid = pv_q[rd_ptr_r];
  assign q_key           = key_q[rd_ptr_r];

endmodule

`default_nettype wire

// ===== hdl/prd_store.sv =====
`default_nettype none

module prd_store #(
  parameter int TIME_WIDTH = prd_pkg::DEFAULT_TIME_WIDTH,
  parameter int DEPTH      = prd_pkg::DEFAULT_RELEASE_DEPTH + 1,
  parameter int CNT_W      = $clog2(DEPTH + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire prd_pkg::store_cmd_t   cmd,
  input  wire logic [TIME_WIDTH-1:0] new_key,
  input  wire logic [TIME_WIDTH:0]   new_dec,
  input  wire logic [TIME_WIDTH:0]   new_pre,
  output logic [TIME_WIDTH:0]        head_dec,
  output logic [TIME_WIDTH:0]        head_pre,
  output logic [CNT_W-1:0]           count
);
  import prd_pkg::*;

  logic [TIME_WIDTH-1:0] key_r [DEPTH];
  logic [TIME_WIDTH:0]   dec_r [DEPTH];
  logic [TIME_WIDTH:0]   pre_r [DEPTH];
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [DEPTH-1:0]      after;

  // each cell decides on its own whether it lies at or past the insert point
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      after[i] = (CNT_W'(i) >= count_r) || (key_r[i] > new_key);
    end
  end

  // row of cells: insert shifts up from the insert point, pop shifts down
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (cmd.ins) begin
          if (after[i]) begin
            key_r[i] <= new_key;
            dec_r[i] <= new_dec;
            pre_r[i] <= new_pre;
          end
        end else if (cmd.pop) begin
          key_r[i] <= key_r[i+1];
          dec_r[i] <= dec_r[i+1];
          pre_r[i] <= pre_r[i+1];
        end
      end
    end else if (i == DEPTH - 1) begin : g_last
      always_ff @(posedge clk) begin
        if (cmd.ins && after[i]) begin
          if (after[i-1]) begin
            key_r[i] <= key_r[i-1];
            dec_r[i] <= dec_r[i-1];
            pre_r[i] <= pre_r[i-1];
          end else begin
            key_r[i] <= new_key;
            dec_r[i] <= new_dec;
            pre_r[i] <= new_pre;
          end
        end
      end
    end else begin : g_mid
      always_ff @(posedge clk) begin
        if (cmd.ins) begin
          if (after[i]) begin
            if (after[i-1]) begin
              key_r[i] <= key_r[i-1];
              dec_r[i] <= dec_r[i-1];
              pre_r[i] <= pre_r[i-1];
            end else begin
              key_r[i] <= new_key;
              dec_r[i] <= new_dec;
              pre_r[i] <= new_pre;
            end
          end
        end else if (cmd.pop) begin
          key_r[i] <= key_r[i+1];
          dec_r[i] <= dec_r[i+1];
          pre_r[i] <= pre_r[i+1];
        end
      end
    end
  end

  // entry count
  always_comb begin
    count_nxt = count_r;
    if (cmd.clr) begin
      count_nxt = '0;
    end else if (cmd.ins) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign head_dec = dec_r[0];
  assign head_pre = pre_r[0];
  assign count    = count_r;

endmodule

`default_nettype wire

// ===== hdl/prd_divider.sv =====
`default_nettype none

module prd_divider (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [prd_pkg::TB_W-1:0] dividend,
  input  wire logic [prd_pkg::TB_W-1:0] divisor,
  output logic                          done,
  output logic [prd_pkg::QR_W-1:0]      quotient_rounded
);
  import prd_pkg::*;

  localparam int CW = $clog2(TB_W);

  logic [TB_W-1:0] rem_r, rem_nxt;
  logic [TB_W-1:0] quo_r, quo_nxt;
  logic [TB_W-1:0] div_r;
  logic [CW-1:0]   cnt_r;
  logic            run_r;
  logic            done_r;

  logic [TB_W:0]   trial;
  logic [TB_W:0]   diff;
  logic            fits;
  logic            round_up;

  // one restoring step per cycle, quotient bits shift in from the right
  assign trial = {rem_r, quo_r[TB_W-1]};
  assign diff  = trial - {1'b0, div_r};
  assign fits  = (trial >= {1'b0, div_r});

  always_comb begin
    rem_nxt = fits ? diff[TB_W-1:0] : trial[TB_W-1:0];
    quo_nxt = {quo_r[TB_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      div_r <= divisor;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= run_r && (cnt_r == '0);
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CW'(TB_W - 1);
      end else if (run_r) begin
        if (cnt_r == '0) begin
          run_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  // round half up: twice the remainder against the divisor
  assign round_up         = ({rem_r, 1'b0} >= {1'b0, div_r});
  assign quotient_rounded = {1'b0, quo_r} + QR_W'(round_up);
  assign done             = done_r;

endmodule

`default_nettype wire

// ===== hdl/prd_back.sv =====
`default_nettype none

module prd_back #(
  parameter int TIME_WIDTH    = prd_pkg::DEFAULT_TIME_WIDTH,
  parameter int RELEASE_DEPTH = prd_pkg::DEFAULT_RELEASE_DEPTH
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic [prd_pkg::TB_W-1:0] time_base,
  input  wire logic                     q_valid,
  output logic                          q_ready,
  input  wire logic                     q_mode,
  input  wire logic [TIME_WIDTH-1:0]    q_decode_time,
  input  wire logic                     q_decode_valid,
  input  wire logic [TIME_WIDTH-1:0]    q_present_time,
  input  wire logic                     q_present_valid,
  input  wire logic [TIME_WIDTH-1:0]    q_key,
  output logic                          out_strobe,
  output logic                          out_released,
  output logic [TIME_WIDTH-1:0]         out_released_time,
  output logic                          out_released_time_ok,
  output logic signed [TIME_WIDTH:0]    out_interval,
  output logic [2:0]                    out_rate_class,
  output logic [$clog2(RELEASE_DEPTH+2)-1:0] out_fill_level
);
  import prd_pkg::*;

  localparam int STORE_DEPTH = RELEASE_DEPTH + 1;
  localparam int CNT_W       = $clog2(RELEASE_DEPTH + 2);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_CHECK = 3'b010,
    ST_DIV   = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic                  pv_r, pv_nxt;
  logic                  strobe_r, strobe_nxt;
  logic                  rel_r, rel_nxt;
  logic [TIME_WIDTH-1:0] rtime_r, rtime_nxt;
  logic                  rok_r, rok_nxt;
  logic [TIME_WIDTH:0]   ival_r, ival_nxt;
  rate_class_t           class_r, class_nxt;
  logic [TIME_WIDTH-1:0] last_time_r, last_time_nxt;
  logic                  last_ok_r, last_ok_nxt;

  store_cmd_t            cmd;
  logic [TIME_WIDTH:0]   head_dec;
  logic [TIME_WIDTH:0]   head_pre;
  logic [CNT_W-1:0]      count;

  logic                  div_start;
  logic                  div_done;
  logic [QR_W-1:0]       rate_q;
  rate_class_t           rate_cls;

  logic [TIME_WIDTH:0]   pick;
  logic [TIME_WIDTH-1:0] ct;
  logic                  pick_ok;
  logic [TIME_WIDTH:0]   diff;
  logic                  later;
  logic                  narrow;
  logic                  release_now;

  prd_store #(
    .TIME_WIDTH (TIME_WIDTH),
    .DEPTH      (STORE_DEPTH),
    .CNT_W      (CNT_W)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .new_key  (q_key),
    .new_dec  ({q_decode_valid, q_decode_time}),
    .new_pre  ({q_present_valid, q_present_time}),
    .head_dec (head_dec),
    .head_pre (head_pre),
    .count    (count)
  );

  prd_divider u_divider (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (div_start),
    .dividend         (time_base),
    .divisor          (diff[TB_W-1:0]),
    .done             (div_done),
    .quotient_rounded (rate_q)
  );

  // head selection and interval against the last taken time
  assign pick        = pv_r ? head_pre : head_dec;
  assign ct          = pick[TIME_WIDTH-1:0];
  assign pick_ok     = pick[TIME_WIDTH];
  assign diff        = {1'b0, ct} - {1'b0, last_time_r};
  assign later       = (diff != '0) && !diff[TIME_WIDTH];
  assign narrow      = (diff[TIME_WIDTH-1:TB_W] == '0);
  assign release_now = (count == CNT_W'(STORE_DEPTH));
  assign rate_cls    = rate_class_of(rate_q);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    q_ready       = 1'b0;
    div_start     = 1'b0;
    pv_nxt        = pv_r;
    strobe_nxt    = 1'b0;
    rel_nxt       = rel_r;
    rtime_nxt     = rtime_r;
    rok_nxt       = rok_r;
    ival_nxt      = ival_r;
    class_nxt     = class_r;
    last_time_nxt = last_time_r;
    last_ok_nxt   = last_ok_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_ready = 1'b1;
          if (q_mode == MODE_FLUSH) begin
            cmd.clr    = 1'b1;
            strobe_nxt = 1'b1;
            rel_nxt    = 1'b0;
            rtime_nxt  = '0;
            rok_nxt    = 1'b0;
            ival_nxt   = '0;
          end else begin
            cmd.ins   = 1'b1;
            pv_nxt    = q_present_valid;
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        // no release unless the store overflowed its release depth
        rel_nxt   = 1'b0;
        rtime_nxt = '0;
        rok_nxt   = 1'b0;
        ival_nxt  = '0;
        state_nxt = ST_IDLE;
        if (release_now) begin
          cmd.pop = 1'b1;
          rel_nxt = 1'b1;
          if (pick_ok) begin
            rtime_nxt     = ct;
            rok_nxt       = 1'b1;
            ival_nxt      = last_ok_r ? diff : '0;
            last_time_nxt = ct;
            last_ok_nxt   = 1'b1;
            if (last_ok_r && later && narrow) begin
              div_start = 1'b1;
              state_nxt = ST_DIV;
            end else begin
              strobe_nxt = 1'b1;
            end
          end else begin
            last_time_nxt = '0;
            last_ok_nxt   = 1'b0;
            strobe_nxt    = 1'b1;
          end
        end else begin
          strobe_nxt = 1'b1;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (rate_cls != RATE_NONE) begin
            class_nxt = rate_cls;
          end
          strobe_nxt = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control and tracked state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      strobe_r    <= 1'b0;
      class_r     <= RATE_NONE;
      last_time_r <= '0;
      last_ok_r   <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      strobe_r    <= strobe_nxt;
      class_r     <= class_nxt;
      last_time_r <= last_time_nxt;
      last_ok_r   <= last_ok_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    pv_r    <= pv_nxt;
    rel_r   <= rel_nxt;
    rtime_r <= rtime_nxt;
    rok_r   <= rok_nxt;
    ival_r  <= ival_nxt;
  end

  assign out_strobe           = strobe_r;
  assign out_released         = rel_r;
  assign out_released_time    = rtime_r;
  assign out_released_time_ok = rok_r;
  assign out_interval         = $signed(ival_r);
  assign out_rate_class       = class_r;
  assign out_fill_level       = count;

endmodule

`default_nettype wire

// ===== hdl/prd_checker.sv =====
`default_nettype none
`include "pts_reorder_rate_detector_defines.svh"

module prd_checker #(
  parameter int RELEASE_DEPTH = prd_pkg::DEFAULT_RELEASE_DEPTH,
  parameter int TIME_WIDTH    = prd_pkg::DEFAULT_TIME_WIDTH
) (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                out_strobe,
  input wire logic                                out_released,
  input wire logic [TIME_WIDTH-1:0]               out_released_time,
  input wire logic                                out_released_time_ok,
  input wire logic signed [TIME_WIDTH:0]          out_interval,
  input wire logic [$clog2(RELEASE_DEPTH+2)-1:0]  out_fill_level
);

  localparam int CNT_W = $clog2(RELEASE_DEPTH + 2);

  // an item without a release carries no time and no interval
  `PRD_ASSERT_IMPL(a_no_release_zero, out_strobe && !out_released, out_released_time == '0 && !out_released_time_ok && out_interval == '0, "result without release carries data")

  // a release leaves the store exactly at its release depth
  `PRD_ASSERT_IMPL(a_release_fill, out_strobe && out_released, out_fill_level == CNT_W'(RELEASE_DEPTH), "release with wrong fill level")

  // an invalid head time gives zero time and zero interval
  `PRD_ASSERT_IMPL(a_invalid_head, out_strobe && out_released && !out_released_time_ok, out_released_time == '0 && out_interval == '0, "invalid head time not cleared")

  // the store never reports more than the release depth on a result
  `PRD_ASSERT_ALWAYS(a_fill_bound, !out_strobe || out_fill_level <= CNT_W'(RELEASE_DEPTH), "fill level above release depth")

endmodule

bind pts_reorder_rate_detector prd_checker #(
  .RELEASE_DEPTH (RELEASE_DEPTH),
  .TIME_WIDTH    (TIME_WIDTH)
) u_prd_checker (.*);

`default_nettype wire
